FILE: rtl/multi2_cbc_block_decrypt_defines.svh
// Assertion macros used by the MULTI2 CBC decryptor core.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef MULTI2_CBC_BLOCK_DECRYPT_DEFINES_SVH
`define MULTI2_CBC_BLOCK_DECRYPT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define M2CBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define M2CBC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/m2cbc_pkg.sv
// Types, constants and the micro-op schedule of the MULTI2 CBC decryptor.
// No dependencies; used by every module of the block.
package m2cbc_pkg;

  localparam int unsigned RegAddrW   = 6;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseW     = $clog2(PhaseCount);
  localparam logic [3:0]  RoundsRst  = 4'd4;

  typedef enum logic [2:0] {
    REG_KEY_A  = 3'd0,
    REG_KEY_B  = 3'd1,
    REG_KEY_C  = 3'd2,
    REG_KEY_D  = 3'd3,
    REG_CHAIN  = 3'd4,
    REG_ROUNDS = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_S1,
    OP_S2,
    OP_S3A,
    OP_S3B,
    OP_S4
  } pi_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } core_state_e;

  typedef struct packed {
    logic [7:0][31:0] wk;
    logic [63:0]      chain_init;
    logic [3:0]       rounds;
  } cfg_t;

  typedef struct packed {
    logic [63:0] cipher;
    logic [3:0]  nbytes;
    logic        chain_start;
  } item_t;

  typedef struct packed {
    logic [63:0] plain;
    logic        partial;
  } result_t;

  typedef struct packed {
    pi_op_e     op;
    logic [2:0] kidx;
  } sched_t;

  // One round as ten micro-ops; the third Pi step takes two of them.
  function automatic sched_t sched_entry(input logic dec, input logic [PhaseW-1:0] phase);
    sched_t s;
    s = '{op: OP_S1, kidx: 3'd0};
    if (dec) begin
      case (phase)
        4'd0: s = '{op: OP_S4,  kidx: 3'd7};
        4'd1: s = '{op: OP_S3A, kidx: 3'd5};
        4'd2: s = '{op: OP_S3B, kidx: 3'd6};
        4'd3: s = '{op: OP_S2,  kidx: 3'd4};
        4'd4: s = '{op: OP_S1,  kidx: 3'd0};
        4'd5: s = '{op: OP_S4,  kidx: 3'd3};
        4'd6: s = '{op: OP_S3A, kidx: 3'd1};
        4'd7: s = '{op: OP_S3B, kidx: 3'd2};
        4'd8: s = '{op: OP_S2,  kidx: 3'd0};
        default: s = '{op: OP_S1, kidx: 3'd0};
      endcase
    end else begin
      case (phase)
        4'd0: s = '{op: OP_S1,  kidx: 3'd0};
        4'd1: s = '{op: OP_S2,  kidx: 3'd0};
        4'd2: s = '{op: OP_S3A, kidx: 3'd1};
        4'd3: s = '{op: OP_S3B, kidx: 3'd2};
        4'd4: s = '{op: OP_S4,  kidx: 3'd3};
        4'd5: s = '{op: OP_S1,  kidx: 3'd0};
        4'd6: s = '{op: OP_S2,  kidx: 3'd4};
        4'd7: s = '{op: OP_S3A, kidx: 3'd5};
        4'd8: s = '{op: OP_S3B, kidx: 3'd6};
        default: s = '{op: OP_S4, kidx: 3'd7};
      endcase
    end
    return s;
  endfunction

  // Keeps the leading nbytes bytes of a block and zeroes the rest.
  function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nbytes) begin
        m[63 - 8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/m2cbc_pi_unit.sv
// Shared MULTI2 Pi step unit: one micro-op on the l and r halves and the t temporary per cycle.
// Depends on m2cbc_pkg for the micro-op codes.
module m2cbc_pi_unit
  import m2cbc_pkg::*;
(
  input  pi_op_e      op_i,
  input  logic [31:0] l_i,
  input  logic [31:0] r_i,
  input  logic [31:0] t_i,
  input  logic [31:0] key_i,
  output logic [31:0] l_o,
  output logic [31:0] r_o,
  output logic [31:0] t_o
);

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned amt);
    return (v << amt) | (v >> (32 - amt));
  endfunction

  logic [31:0] sum_r, sum_l, sum_t;
  logic [31:0] s2_a, s2_b;
  logic [31:0] s3_a, s3_b;
  logic [31:0] s3_c;
  logic [31:0] s4_a;

  assign sum_r = r_i + key_i;
  assign sum_l = l_i + key_i;
  assign sum_t = t_i + key_i;

  assign s2_a = rotl(sum_r, 1) + sum_r - 32'd1;
  assign s2_b = rotl(s2_a, 4) ^ s2_a;

  assign s3_a = rotl(sum_l, 2) + sum_l + 32'd1;
  assign s3_b = rotl(s3_a, 8) ^ s3_a;

  assign s3_c = rotl(sum_t, 1) - sum_t;

  assign s4_a = rotl(sum_r, 2) + sum_r + 32'd1;

  always_comb begin
    l_o = l_i;
    r_o = r_i;
    t_o = t_i;
    unique case (op_i)
      OP_S1:  r_o = r_i ^ l_i;
      OP_S2:  l_o = l_i ^ s2_b;
      OP_S3A: t_o = s3_b;
      OP_S3B: r_o = r_i ^ (rotl(s3_c, 16) ^ (s3_c | l_i));
      OP_S4:  l_o = l_i ^ s4_a;
      default: begin
        l_o = l_i;
        r_o = r_i;
        t_o = t_i;
      end
    endcase
  end

endmodule

FILE: rtl/m2cbc_regs.sv
// APB register file: four work key pairs, the initial chain value and the round count.
// Depends on m2cbc_pkg for the register indexes and the configuration struct.
module m2cbc_regs
  import m2cbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q, chain_init_q;
  logic [3:0]  rounds_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q      <= '0;
      key_b_q      <= '0;
      key_c_q      <= '0;
      key_d_q      <= '0;
      chain_init_q <= '0;
      rounds_q     <= RoundsRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_A:  key_a_q      <= pwdata;
        REG_KEY_B:  key_b_q      <= pwdata;
        REG_KEY_C:  key_c_q      <= pwdata;
        REG_KEY_D:  key_d_q      <= pwdata;
        REG_CHAIN:  chain_init_q <= pwdata;
        REG_ROUNDS: rounds_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_A:  prdata = key_a_q;
      REG_KEY_B:  prdata = key_b_q;
      REG_KEY_C:  prdata = key_c_q;
      REG_KEY_D:  prdata = key_d_q;
      REG_CHAIN:  prdata = chain_init_q;
      REG_ROUNDS: prdata = {60'd0, rounds_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.wk[0]      = key_a_q[63:32];
    cfg_o.wk[1]      = key_a_q[31:0];
    cfg_o.wk[2]      = key_b_q[63:32];
    cfg_o.wk[3]      = key_b_q[31:0];
    cfg_o.wk[4]      = key_c_q[63:32];
    cfg_o.wk[5]      = key_c_q[31:0];
    cfg_o.wk[6]      = key_d_q[63:32];
    cfg_o.wk[7]      = key_d_q[31:0];
    cfg_o.chain_init = chain_init_q;
    cfg_o.rounds     = rounds_q;
  end

endmodule

FILE: rtl/m2cbc_core.sv
// Sequencer and datapath: runs the Pi micro-ops of one word and keeps the chain register.
// Depends on m2cbc_pkg, m2cbc_pi_unit and the assertion macro header.
`include "multi2_cbc_block_decrypt_defines.svh"

module m2cbc_core
  import m2cbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  core_state_e       state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [3:0]        round_q, round_d;
  logic [63:0]       chain_q, chain_d;
  logic [31:0]       l_q, l_d, r_q, r_d, t_q, t_d;
  logic [63:0]       ct_q, ct_d;
  logic [3:0]        nb_q, nb_d;
  logic [63:0]       chain_sel;
  sched_t            sched;
  logic [31:0]       pi_l, pi_r, pi_t;
  logic [63:0]       lr;

  assign sched = sched_entry(nb_q[3], phase_q);
  assign lr    = {l_q, r_q};

  m2cbc_pi_unit u_pi (
    .op_i  (sched.op),
    .l_i   (l_q),
    .r_i   (r_q),
    .t_i   (t_q),
    .key_i (cfg_i.wk[sched.kidx]),
    .l_o   (pi_l),
    .r_o   (pi_r),
    .t_o   (pi_t)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      round_q <= '0;
      chain_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      round_q <= round_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q  <= l_d;
    r_q  <= r_d;
    t_q  <= t_d;
    ct_q <= ct_d;
    nb_q <= nb_d;
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    round_d   = round_q;
    chain_d   = chain_q;
    l_d       = l_q;
    r_d       = r_q;
    t_d       = t_q;
    ct_d      = ct_q;
    nb_d      = nb_q;
    chain_sel = item_i.chain_start ? cfg_i.chain_init : chain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          chain_d = chain_sel;
          ct_d    = item_i.cipher;
          nb_d    = item_i.nbytes;
          phase_d = '0;
          round_d = '0;
          if (item_i.nbytes[3]) begin
            {l_d, r_d} = item_i.cipher;
          end else begin
            {l_d, r_d} = chain_sel;
          end
          if (item_i.nbytes == 4'd0 || cfg_i.rounds == 4'd0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        l_d = pi_l;
        r_d = pi_r;
        t_d = pi_t;
        if (phase_q == PhaseW'(PhaseCount - 1)) begin
          phase_d = '0;
          round_d = round_q + 4'd1;
          if (round_q + 4'd1 == cfg_i.rounds) begin
            state_d = ST_DONE;
          end
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
          if (nb_q[3]) begin
            chain_d = ct_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  assign res_o.partial = ~nb_q[3];
  assign res_o.plain   = nb_q[3] ? (lr ^ chain_q) : ((ct_q ^ lr) & byte_mask(nb_q));

  `M2CBC_NEVER(a_phase_range, clk_i, rst_ni, phase_q > PhaseW'(PhaseCount - 1),
               "micro-op phase ran past the end of a round")
  `M2CBC_ASSERT(a_run_exit, clk_i, rst_ni,
                (state_q == ST_RUN) |=> (state_q == ST_RUN || state_q == ST_DONE),
                "left the round loop without finishing")
  `M2CBC_ASSERT(a_chain_hold, clk_i, rst_ni,
                (state_q == ST_RUN) |=> $stable(chain_q),
                "chain register changed while rounds were running")
  `M2CBC_ASSERT(a_done_wait, clk_i, rst_ni,
                (state_q == ST_DONE && !res_ready_i) |=> (state_q == ST_DONE && $stable(res_o)),
                "result changed while waiting for the output register")

endmodule

FILE: rtl/multi2_cbc_block_decrypt.sv
// MULTI2 CBC block decryptor with a keystream path for a final short block.
// Depends on m2cbc_pkg, m2cbc_regs and m2cbc_core.
//
//   channel  | direction | handshake                  | payload
//   input    | in        | in_valid_i / in_stall_o    | cipher_block_i, valid_bytes_i, chain_start_i
//   output   | out       | out_valid_o / out_stall_i  | plain_block_o, was_partial_o
//   config   | in        | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// A full word runs round_count rounds; the shared Pi unit runs ten micro-ops a round.
// A short word runs the same loop, in encrypt order, over the chain value; zero bytes or zero rounds skip it.
// Reset clears the chain register, loads the work keys with zero and the round count with four.
// in_stall_o is high while a word is in work or its result waits to enter the output register.
module multi2_cbc_block_decrypt
  import m2cbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         cipher_block_i,
  input  logic [3:0]          valid_bytes_i,
  input  logic                chain_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         plain_block_o,
  output logic                was_partial_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    busy, res_valid, load, accept;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  m2cbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item   = '{cipher: cipher_block_i, nbytes: valid_bytes_i, chain_start: chain_start_i};
  assign accept = in_valid_i & ~busy;

  m2cbc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (accept),
    .item_i      (item),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (load),
    .res_o       (res)
  );

  assign load        = res_valid & (~out_valid_q | ~out_stall_i);
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign in_stall_o    = busy;
  assign out_valid_o   = out_valid_q;
  assign plain_block_o = out_q.plain;
  assign was_partial_o = out_q.partial;

endmodule
